// ----- rtl/core/slsi_pkg.sv -----
`timescale 1ns / 1ps

package slsi_pkg;

  localparam int LIT_W     = 32;
  localparam int IDX_W     = 6;
  localparam int CMD_W     = 2;
  localparam int CNT_OUT_W = 7;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [LIT_W-1:0] literal;
    logic [IDX_W-1:0]        index;
  } in_t;

  typedef struct packed {
    logic signed [LIT_W-1:0] entry_value;
    logic [CNT_OUT_W-1:0]    count;
    logic                    emptied;
    logic                    overflow;
  } out_t;

  // most negative value maps to 2^31 as an unsigned magnitude
  function automatic logic [LIT_W-1:0] magnitude(input logic [LIT_W-1:0] v);
    return v[LIT_W-1] ? (LIT_W'(0) - v) : v;
  endfunction

endpackage

// ----- rtl/core/slsi_ram.sv -----
`timescale 1ns / 1ps

module slsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/core/sorted_literal_set_insert_unit.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | in_data_i  (slsi_pkg::in_t)
// out     | output    | out_valid_o / out_stall_i | out_data_o (slsi_pkg::out_t)
//
// One item at a time through a single-port-write, single-port-read RAM.
// Clear, unused command, zero or full-store add, read past count: straight to the result.
// Read: waits for the RAM word. Add: compares up to PREFIX leading entries by magnitude,
// then matches, appends or inserts sorted, one entry moved per cycle. Reset clears
// all registers but not the RAM. A result stalled in the output register lets one more
// item run, which then waits in its final state until that register frees.

module sorted_literal_set_insert_unit #(
  parameter int CAPACITY = 64,
  parameter int PREFIX   = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  slsi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output slsi_pkg::out_t out_data_o
);

  import slsi_pkg::*;

  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int PREF_EFF = (PREFIX < CAPACITY) ? PREFIX : CAPACITY;
  localparam int XW       = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] PREF_C = CW'(PREF_EFF);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCMP,
    S_PLACE,
    S_SHIFT,
    S_INS,
    S_RDWAIT,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    bound_q, bound_d;
  logic [CW-1:0]    k_q, k_d;
  logic [LIT_W-1:0] lit_q, lit_d;
  logic [LIT_W-1:0] res_value_q, res_value_d;
  logic             res_emptied_q, res_emptied_d;
  logic             res_overflow_q, res_overflow_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [LIT_W-1:0] ram_wdata, ram_rdata;

  logic             accept;
  logic [LIT_W-1:0] entry_mag, lit_mag;
  logic [CW-1:0]    pos_inc, k_dec, k_dec2, cnt_dec;

  slsi_ram #(
    .WIDTH (LIT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign entry_mag = magnitude(ram_rdata);
  assign lit_mag   = magnitude(lit_q);
  assign pos_inc   = pos_q + CW'(1);
  assign k_dec     = k_q - CW'(1);
  assign k_dec2    = k_q - CW'(2);
  assign cnt_dec   = count_q - CW'(1);

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    pos_d          = pos_q;
    bound_d        = bound_q;
    k_d            = k_q;
    lit_d          = lit_q;
    res_value_d    = res_value_q;
    res_emptied_d  = res_emptied_q;
    res_overflow_d = res_overflow_q;
    out_valid_d    = out_valid_q;
    out_d          = out_q;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = lit_q;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          lit_d          = in_data_i.literal;
          res_value_d    = '0;
          res_emptied_d  = 1'b0;
          res_overflow_d = 1'b0;
          pos_d          = '0;
          state_d        = S_DONE;
          case (in_data_i.command)
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_ADD: begin
              if (in_data_i.literal == '0) begin
                state_d = S_DONE;
              end else if (count_q >= CAP_C) begin
                res_overflow_d = 1'b1;
              end else if (count_q == '0) begin
                state_d = S_PLACE;
              end else begin
                bound_d   = (count_q < PREF_C) ? count_q : PREF_C;
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = S_SCMP;
              end
            end
            CMD_READ: begin
              if (XW'(in_data_i.index) < XW'(count_q)) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_data_i.index);
                state_d   = S_RDWAIT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCMP: begin
        if (entry_mag > lit_mag) begin
          state_d = S_PLACE;
        end else if (entry_mag == lit_mag) begin
          if (ram_rdata != lit_q) begin
            count_d       = '0;
            res_emptied_d = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          pos_d = pos_inc;
          if (pos_inc == bound_q) begin
            state_d = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_inc[AW-1:0];
          end
        end
      end
      S_PLACE: begin
        if (count_q < PREF_C) begin
          if (count_q > pos_q) begin
            ram_re    = 1'b1;
            ram_raddr = cnt_dec[AW-1:0];
            k_d       = count_q;
            state_d   = S_SHIFT;
          end else begin
            state_d = S_INS;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_q[AW-1:0];
          count_d   = count_q + CW'(1);
          state_d   = S_DONE;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = ram_rdata;
        k_d       = k_dec;
        if (k_dec == pos_q) begin
          state_d = S_INS;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_dec2[AW-1:0];
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        count_d   = count_q + CW'(1);
        state_d   = S_DONE;
      end
      S_RDWAIT: begin
        res_value_d = ram_rdata;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.entry_value = $signed(res_value_q);
          out_d.count       = CNT_OUT_W'(count_q);
          out_d.emptied     = res_emptied_q;
          out_d.overflow    = res_overflow_q;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      pos_q          <= '0;
      bound_q        <= '0;
      k_q            <= '0;
      lit_q          <= '0;
      res_value_q    <= '0;
      res_emptied_q  <= 1'b0;
      res_overflow_q <= 1'b0;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      pos_q          <= pos_d;
      bound_q        <= bound_d;
      k_q            <= k_d;
      lit_q          <= lit_d;
      res_value_q    <= res_value_d;
      res_emptied_q  <= res_emptied_d;
      res_overflow_q <= res_overflow_d;
      out_valid_q    <= out_valid_d;
      out_q          <= out_d;
    end
  end

endmodule
